// ----- src/epsm_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// epsm_pkg
// Shared types and constants of the encoder period speed meter.
// -----------------------------------------------------------------------------
package epsm_pkg;

	localparam int TIME_BITS_DEF = 32;

	// timer_hz * 6000 stays below 2^40 for any 27-bit timer_hz
	localparam int NUM_W = 40;
	localparam logic [12:0] CENTI_MIN_FACTOR = 13'd6000;

	localparam int PPR_W     = 16;
	localparam int HZ_W      = 27;
	localparam int TIMEOUT_W = 16;
	localparam int TICK_W    = 10;
	localparam int IDLE_W    = 16;
	localparam int CFG_W     = 27;
	localparam int CFG_IDX_W = 2;

	localparam logic [PPR_W-1:0]     PPR_RST     = 16'd95;
	localparam logic [HZ_W-1:0]      HZ_RST      = 27'd16000000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd200;
	localparam logic [TICK_W-1:0]    TICK_RST    = 10'd10;

	localparam logic [CFG_IDX_W-1:0] REG_PPR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HZ      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK    = 2'd3;

	localparam logic KIND_CAPTURE = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 104;

	typedef struct packed {
		logic take_cap;
		logic take_tick;
		logic div_go1;
		logic div_go2;
		logic spd_div;
		logic spd_max;
		logic timeout;
		logic load_out;
	} epsm_cmd_t;

	typedef struct packed {
		logic need_div;
		logic ppr_zero;
		logic div_busy;
	} epsm_sts_t;

endpackage
`default_nettype wire

// ----- src/epsm_div.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// epsm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module epsm_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic [DVD_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the top trial bit drops out
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- src/epsm_dp.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// epsm_dp
// Datapath: config registers, encoder state, speed divider, result register.
// -----------------------------------------------------------------------------
module epsm_dp
	import epsm_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire epsm_cmd_t            cmd,
	output epsm_sts_t                 sts,
	output logic [M_TDATA_W-1:0]      m_tdata
);

	logic [PPR_W-1:0]     ppr_q;
	logic [HZ_W-1:0]      hz_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TICK_W-1:0]    tick_q;

	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] period_q;
	logic [31:0]          pos_q;
	logic                 dir_q;
	logic                 pend_q;
	logic [IDLE_W-1:0]    idle_q;
	logic [31:0]          speed_q;
	logic [NUM_W-1:0]     num_q;
	logic [M_TDATA_W-1:0] out_q;

	logic [TIME_BITS-1:0] ts;
	logic                 dir_in;
	logic [IDLE_W:0]      idle_sum;
	logic                 stopped;

	logic                 div_start;
	logic [NUM_W-1:0]     div_dvd;
	logic [TIME_BITS-1:0] div_dvs;
	logic                 div_busy;
	logic [NUM_W-1:0]     div_quo;

	assign ts       = TIME_BITS'(s_tdata[31:0]);
	assign dir_in   = s_tdata[32];
	assign idle_sum = {1'b0, idle_q} + (IDLE_W + 1)'(tick_q);
	assign stopped  = (idle_q > timeout_q);

	// first pass divides by the period, second by pulses per revolution
	assign div_start = cmd.div_go1 | cmd.div_go2;
	assign div_dvd   = cmd.div_go1 ? num_q : div_quo;
	assign div_dvs   = cmd.div_go1 ? period_q : TIME_BITS'(ppr_q);

	epsm_div #(
		.DVD_W(NUM_W),
		.DVS_W(TIME_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= PPR_RST;
			hz_q      <= HZ_RST;
			timeout_q <= TIMEOUT_RST;
			tick_q    <= TICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PPR:     ppr_q     <= cfg_data[PPR_W-1:0];
				REG_HZ:      hz_q      <= cfg_data[HZ_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				REG_TICK:    tick_q    <= cfg_data[TICK_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			period_q <= '0;
			pos_q    <= '0;
			dir_q    <= 1'b1;
			pend_q   <= 1'b0;
			idle_q   <= '0;
			speed_q  <= '0;
		end else begin
			if (cmd.take_cap) begin
				period_q <= ts - last_q;
				last_q   <= ts;
				dir_q    <= dir_in;
				pos_q    <= dir_in ? pos_q + 32'd1 : pos_q - 32'd1;
				pend_q   <= 1'b1;
				idle_q   <= '0;
			end
			if (cmd.take_tick) begin
				idle_q <= idle_sum[IDLE_W] ? {IDLE_W{1'b1}} : idle_sum[IDLE_W-1:0];
				pend_q <= 1'b0;
			end
			if (cmd.spd_max) begin
				speed_q <= '1;
			end
			if (cmd.spd_div) begin
				speed_q <= (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
			end
			if (cmd.timeout && stopped) begin
				speed_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_tick) begin
			num_q <= {13'd0, hz_q} * {27'd0, CENTI_MIN_FACTOR};
		end
		if (cmd.load_out) begin
			out_q <= {6'd0, stopped, speed_q, 32'(period_q), dir_q, pos_q};
		end
	end

	assign sts.need_div = pend_q && (period_q != '0);
	assign sts.ppr_zero = (ppr_q == '0);
	assign sts.div_busy = div_busy;
	assign m_tdata      = out_q;

endmodule
`default_nettype wire

// ----- src/epsm_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// epsm_ctrl
// Sequencer: item intake, the two divider passes, timeout and result hand-off.
// -----------------------------------------------------------------------------
module epsm_ctrl
	import epsm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      s_tuser,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire epsm_sts_t sts,
	output epsm_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1_GO,
		S_DIV1,
		S_DIV2_GO,
		S_DIV2,
		S_FIN,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.take_cap  = take && (s_tuser == KIND_CAPTURE);
		cmd.take_tick = take && (s_tuser == KIND_TICK);
		cmd.spd_max   = cmd.take_tick && sts.need_div && sts.ppr_zero;
		cmd.div_go1   = (state_q == S_DIV1_GO);
		cmd.div_go2   = (state_q == S_DIV2_GO);
		cmd.spd_div   = (state_q == S_DIV2) && !sts.div_busy;
		cmd.timeout   = (state_q == S_FIN);
		cmd.load_out  = (state_q == S_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.take_cap) begin
						state_q <= S_EMIT;
					end else if (cmd.take_tick) begin
						state_q <= (sts.need_div && !sts.ppr_zero) ? S_DIV1_GO : S_FIN;
					end
				end
				S_DIV1_GO: state_q <= S_DIV1;
				S_DIV1: begin
					if (!sts.div_busy) begin
						state_q <= S_DIV2_GO;
					end
				end
				S_DIV2_GO: state_q <= S_DIV2;
				S_DIV2: begin
					if (!sts.div_busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/encoder_period_speed_meter_unit.sv -----
// Capture item: the result register loads in S_EMIT, once the output is free.
// Tick without a speed update: passes S_FIN, then loads in S_EMIT.
// A tick that computes a speed runs two passes of the radix-2 divider (period,
// then pulses per rev) before S_FIN and S_EMIT, where the result register loads.
// One item is in work at a time; the next is taken while a result waits.
// arst_n clears the encoder state, sets the direction to forward and loads the register defaults.
`default_nettype none
// -----------------------------------------------------------------------------
// encoder_period_speed_meter_unit
// Single-channel encoder tachometer: position, period and speed in centi-RPM.
// -----------------------------------------------------------------------------
module encoder_period_speed_meter_unit
	import epsm_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // timestamp[31:0], dir_level[32], zero
	input  wire logic                 s_tuser,  // kind
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata   // position[31:0], direction_fwd[32],
	                                            // period_ticks[64:33],
	                                            // speed_centi_rpm[96:65], stopped[97]
);

	epsm_cmd_t cmd;
	epsm_sts_t sts;

	epsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	epsm_dp #(
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

endmodule
`default_nettype wire
